### rtl/core/kstc_pkg.sv
// Package for the keypad-set time-of-day clock.
// Holds the item codes, key codes, cursor positions, limits and the result struct.
// No dependencies; every other file of the block imports it.
package kstc_pkg;

    // Item kinds carried on the func field. Code 3 has no meaning and is ignored.
    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_KEY      = 2'd1,
        FUNC_SET_MODE = 2'd2
    } func_t;

    // Keypad codes with a special meaning. Codes below KEY_DIGIT_LIMIT are digits.
    localparam logic [3:0] KEY_CLEAR       = 4'hC;
    localparam logic [3:0] KEY_EXIT        = 4'hF;
    localparam logic [3:0] KEY_DIGIT_LIMIT = 4'd10;

    // Cursor positions, left to right.
    localparam logic [2:0] CUR_HOUR_TENS   = 3'd0;
    localparam logic [2:0] CUR_HOUR_UNITS  = 3'd1;
    localparam logic [2:0] CUR_MIN_TENS    = 3'd2;
    localparam logic [2:0] CUR_MIN_UNITS   = 3'd3;
    localparam logic [2:0] CUR_SEC_TENS    = 3'd4;
    localparam logic [2:0] CUR_SEC_UNITS   = 3'd5;

    // Configuration register indexes.
    localparam logic REG_TICKS_PER_SECOND = 1'b0;
    localparam logic REG_IDLE_LIMIT       = 1'b1;

    // Limits and reset values.
    localparam logic [3:0] IDLE_MAX          = 4'd12;
    localparam logic [6:0] SEC_PER_MIN       = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY     = 6'd24;
    localparam logic [3:0] TICKS_PER_SEC_RST = 4'd10;
    localparam logic [3:0] IDLE_LIMIT_RST    = 4'd10;

    // One result beat.
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [2:0] cursor;
        logic       editing;
        logic       beep;
        logic [3:0] idle_seconds;
    } result_t;

    // Configuration values seen by the update logic.
    typedef struct packed {
        logic [3:0] ticks_per_second;
        logic [3:0] idle_limit;
    } cfg_t;

    // Tens digit times ten, as shifts and an add.
    function automatic logic [6:0] times_ten(input logic [2:0] tens);
        logic [6:0] wide;
        begin
            wide = {4'd0, tens};
            return (wide << 3) + (wide << 1);
        end
    endfunction

endpackage

### rtl/core/keypad_set_time_of_day_clock.sv
// A beat goes from the input register through the engine into the result register.
// Throughput: one beat per cycle unless a held result stalls; the only feedback
// path is the engine's combinational state update, so it never holds a beat back.
// Reset (rst_n low, asynchronous) clears the time to 00:00:00, the cursor, the
// tick and idle counters, selects run mode, sets both configuration registers to
// 10 and empties the input and result registers.
module keypad_set_time_of_day_clock (
    input  logic       clk,
    input  logic       rst_n,
    // Input channel.
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [3:0] key_code,
    // Result channel.
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] hours,
    output logic [5:0] minutes,
    output logic [5:0] seconds,
    output logic [2:0] cursor,
    output logic       editing,
    output logic       beep,
    output logic [3:0] idle_seconds,
    // Configuration write port.
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);
    import kstc_pkg::*;

    logic       held_valid;
    logic [1:0] held_func;
    logic [3:0] held_key;
    logic       out_free;
    logic       fire;
    cfg_t       cfg_reg;
    result_t    result_next;
    result_t    result_reg;
    logic       out_valid_reg;

    // Configuration registers. Writes must happen only while the block is idle, which
    // the block does not enforce, so the engine sees stable values for a beat in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_second <= TICKS_PER_SEC_RST;
            cfg_reg.idle_limit       <= IDLE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_data;
                REG_IDLE_LIMIT:       cfg_reg.idle_limit       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The result register is free when empty or when its beat is being taken.
    // A held input beat moves through the engine into it exactly then, so the
    // input side keeps flowing while a result waits only if the result is taken.
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = held_valid && out_free;

    kstc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .key_code   (key_code),
        .take       (fire),
        .held_valid (held_valid),
        .held_func  (held_func),
        .held_key   (held_key)
    );

    kstc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .func   (held_func),
        .key    (held_key),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    // Result register: valid is control state, the payload loads on a fire.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= held_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hours        = result_reg.hours;
    assign minutes      = result_reg.minutes;
    assign seconds      = result_reg.seconds;
    assign cursor       = result_reg.cursor;
    assign editing      = result_reg.editing;
    assign beep         = result_reg.beep;
    assign idle_seconds = result_reg.idle_seconds;

endmodule

### rtl/core/kstc_in_stage.sv
// Input register of the keypad-set time-of-day clock.
// Captures one input beat and holds it until the update stage takes it.
// Depends on kstc_pkg.
module kstc_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [3:0] key_code,
    input  logic       take,
    output logic       held_valid,
    output logic [1:0] held_func,
    output logic [3:0] held_key
);
    import kstc_pkg::*;

    logic       valid_reg;
    logic [1:0] func_reg;
    logic [3:0] key_reg;
    logic       load;

    // The register is free when empty or when its beat moves on this cycle.
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg <= func;
            key_reg  <= key_code;
        end
    end

    assign held_valid = valid_reg;
    assign held_func  = func_reg;
    assign held_key   = key_reg;

endmodule

### rtl/core/kstc_engine.sv
// Time-of-day state and its single-pass update for the keypad-set clock.
// Holds digits, counts, cursor, tick and idle counters and the set-mode flag.
// Depends on kstc_pkg.
module kstc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [1:0]       func,
    input  logic [3:0]       key,
    input  kstc_pkg::cfg_t   cfg,
    output kstc_pkg::result_t result
);
    import kstc_pkg::*;

    logic [1:0] hour_tens_reg,    hour_tens_next;
    logic [3:0] hour_units_reg,   hour_units_next;
    logic [2:0] minute_tens_reg,  minute_tens_next;
    logic [3:0] minute_units_reg, minute_units_next;
    logic [2:0] second_tens_reg,  second_tens_next;
    logic [3:0] second_units_reg, second_units_next;
    logic [2:0] cursor_reg,       cursor_next;
    logic [4:0] hour_count_reg,   hour_count_next;
    logic [5:0] minute_count_reg, minute_count_next;
    logic [5:0] second_count_reg, second_count_next;
    logic [3:0] tick_count_reg,   tick_count_next;
    logic [3:0] idle_count_reg,   idle_count_next;
    logic       set_mode_reg,     set_mode_next;
    logic       beep;

    always_comb
    begin
        logic [3:0] tick_inc;
        logic       second_done;
        logic [6:0] sec_inc;
        logic [6:0] min_inc;
        logic [5:0] hour_inc;
        logic       accepted;
        logic       known_cursor;
        logic [6:0] hour_sum;
        logic [6:0] minute_sum;
        logic [6:0] second_sum;

        hour_tens_next    = hour_tens_reg;
        hour_units_next   = hour_units_reg;
        minute_tens_next  = minute_tens_reg;
        minute_units_next = minute_units_reg;
        second_tens_next  = second_tens_reg;
        second_units_next = second_units_reg;
        cursor_next       = cursor_reg;
        hour_count_next   = hour_count_reg;
        minute_count_next = minute_count_reg;
        second_count_next = second_count_reg;
        tick_count_next   = tick_count_reg;
        idle_count_next   = idle_count_reg;
        set_mode_next     = set_mode_reg;
        beep              = 1'b0;

        tick_inc     = tick_count_reg + 4'd1;
        second_done  = (tick_inc >= cfg.ticks_per_second);
        sec_inc      = {1'b0, second_count_reg} + 7'd1;
        min_inc      = {1'b0, minute_count_reg} + 7'd1;
        hour_inc     = {1'b0, hour_count_reg} + 6'd1;
        accepted     = 1'b1;
        known_cursor = 1'b1;
        hour_sum     = 7'd0;
        minute_sum   = 7'd0;
        second_sum   = 7'd0;

        unique case (func_t'(func))
            FUNC_TICK:
            begin
                tick_count_next = second_done ? 4'd0 : tick_inc;
                if (!set_mode_reg)
                begin
                    // Seconds carry into minutes, minutes into hours.
                    if (second_done)
                    begin
                        if (sec_inc >= SEC_PER_MIN)
                        begin
                            second_count_next = 6'd0;
                            if (min_inc >= SEC_PER_MIN)
                            begin
                                minute_count_next = 6'd0;
                                hour_count_next   = (hour_inc >= HOURS_PER_DAY) ?
                                                    5'd0 : hour_inc[4:0];
                            end
                            else
                            begin
                                minute_count_next = min_inc[5:0];
                            end
                        end
                        else
                        begin
                            second_count_next = sec_inc[5:0];
                        end
                    end
                end
                else
                begin
                    if (second_done && idle_count_reg < IDLE_MAX)
                    begin
                        idle_count_next = idle_count_reg + 4'd1;
                    end
                    if (idle_count_next >= cfg.idle_limit)
                    begin
                        set_mode_next   = 1'b0;
                        tick_count_next = 4'd0;
                    end
                end
            end
            FUNC_KEY:
            begin
                if (set_mode_reg)
                begin
                    idle_count_next = 4'd0;
                    if (key == KEY_CLEAR)
                    begin
                        hour_tens_next    = 2'd0;
                        hour_units_next   = 4'd0;
                        minute_tens_next  = 3'd0;
                        minute_units_next = 4'd0;
                        second_tens_next  = 3'd0;
                        second_units_next = 4'd0;
                        cursor_next       = CUR_HOUR_TENS;
                        hour_count_next   = 5'd0;
                        minute_count_next = 6'd0;
                        second_count_next = 6'd0;
                    end
                    else if (key < KEY_DIGIT_LIMIT)
                    begin
                        unique case (cursor_reg)
                            CUR_HOUR_TENS:
                            begin
                                accepted = (key < 4'd3);
                                if (accepted) hour_tens_next = key[1:0];
                            end
                            CUR_HOUR_UNITS:
                            begin
                                accepted = (hour_tens_reg < 2'd2) || (key < 4'd4);
                                if (accepted) hour_units_next = key;
                            end
                            CUR_MIN_TENS:
                            begin
                                accepted = (key < 4'd6);
                                if (accepted) minute_tens_next = key[2:0];
                            end
                            CUR_MIN_UNITS:
                            begin
                                minute_units_next = key;
                            end
                            CUR_SEC_TENS:
                            begin
                                accepted = (key < 4'd6);
                                if (accepted) second_tens_next = key[2:0];
                            end
                            CUR_SEC_UNITS:
                            begin
                                second_units_next = key;
                            end
                            default:
                            begin
                                known_cursor = 1'b0;
                            end
                        endcase
                        if (known_cursor)
                        begin
                            beep = !accepted;
                            if (accepted)
                            begin
                                cursor_next = (cursor_reg >= CUR_SEC_UNITS) ?
                                              CUR_HOUR_TENS : cursor_reg + 3'd1;
                            end
                            // Counts are rebuilt from the digits after every digit key.
                            hour_sum   = times_ten({1'b0, hour_tens_next}) +
                                         {3'd0, hour_units_next};
                            minute_sum = times_ten(minute_tens_next) +
                                         {3'd0, minute_units_next};
                            second_sum = times_ten(second_tens_next) +
                                         {3'd0, second_units_next};
                            hour_count_next   = hour_sum[4:0];
                            minute_count_next = minute_sum[5:0];
                            second_count_next = second_sum[5:0];
                        end
                    end
                    else if (key == KEY_EXIT)
                    begin
                        set_mode_next   = 1'b0;
                        tick_count_next = 4'd0;
                    end
                end
            end
            FUNC_SET_MODE:
            begin
                set_mode_next   = 1'b1;
                idle_count_next = 4'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_tens_reg    <= 2'd0;
            hour_units_reg   <= 4'd0;
            minute_tens_reg  <= 3'd0;
            minute_units_reg <= 4'd0;
            second_tens_reg  <= 3'd0;
            second_units_reg <= 4'd0;
            cursor_reg       <= CUR_HOUR_TENS;
            hour_count_reg   <= 5'd0;
            minute_count_reg <= 6'd0;
            second_count_reg <= 6'd0;
            tick_count_reg   <= 4'd0;
            idle_count_reg   <= 4'd0;
            set_mode_reg     <= 1'b0;
        end
        else if (fire)
        begin
            hour_tens_reg    <= hour_tens_next;
            hour_units_reg   <= hour_units_next;
            minute_tens_reg  <= minute_tens_next;
            minute_units_reg <= minute_units_next;
            second_tens_reg  <= second_tens_next;
            second_units_reg <= second_units_next;
            cursor_reg       <= cursor_next;
            hour_count_reg   <= hour_count_next;
            minute_count_reg <= minute_count_next;
            second_count_reg <= second_count_next;
            tick_count_reg   <= tick_count_next;
            idle_count_reg   <= idle_count_next;
            set_mode_reg     <= set_mode_next;
        end
    end

    always_comb
    begin
        result.hours        = hour_count_next;
        result.minutes      = minute_count_next;
        result.seconds      = second_count_next;
        result.cursor       = cursor_next;
        result.editing      = set_mode_next;
        result.beep         = beep;
        result.idle_seconds = idle_count_next;
    end

endmodule

### rtl/core/kstc_checker.sv
// Port-level checks for the keypad-set time-of-day clock.
// Sees only the top-level ports; bound to keypad_set_time_of_day_clock below.
// Depends on kstc_pkg.
module kstc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] hours,
    input logic [5:0] minutes,
    input logic [5:0] seconds,
    input logic [2:0] cursor,
    input logic       editing,
    input logic       beep,
    input logic [3:0] idle_seconds
);
    import kstc_pkg::*;

    // Input backpressure only comes from a result beat that is held.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled result beat");

    // A rejected digit only happens in set mode, and the cursor stays in range.
    a_beep_edit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && beep) |-> (editing && cursor <= CUR_SEC_UNITS))
        else $error("beep outside set mode or cursor out of range");

    // Minutes, seconds and idle count stay inside their ranges.
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (minutes < 6'd60 && seconds < 6'd60 && idle_seconds <= IDLE_MAX))
        else $error("result field out of range");

    // A stalled result beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(hours) && $stable(minutes)
            && $stable(seconds) && $stable(cursor) && $stable(editing) && $stable(beep)
            && $stable(idle_seconds)))
        else $error("stalled result beat changed");

endmodule

bind keypad_set_time_of_day_clock kstc_checker u_kstc_checker (.*);

### tb/keypad_set_time_of_day_clock_tb.sv
// Self-checking testbench for the keypad-set HH:MM:SS time-of-day clock.
// A shadow model predicts every result beat, and a scoreboard compares it with the block.
// Depends on kstc_pkg and the keypad_set_time_of_day_clock RTL only.
module keypad_set_time_of_day_clock_tb;
    import kstc_pkg::*;

    // The func field has one code with no meaning; the block must ignore it.
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         SETTLE_TICKS = 12;
    localparam int         RANDOM_BEATS = 850;
    localparam int         PHASES       = 7;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] key;
    } beat_t;

    // Block ports. Every input has a known value from time zero.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [1:0] func      = FUNC_TICK;
    logic [3:0] key_code  = 4'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] cursor;
    logic       editing;
    logic       beep;
    logic [3:0] idle_seconds;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = REG_TICKS_PER_SECOND;
    logic [3:0] cfg_data  = 4'd0;

    keypad_set_time_of_day_clock u_top (.*);

    // Beats waiting to be sent, and the clock readings the block owes us.
    beat_t   beats_to_send[$];
    result_t expected_times[$];

    // Shadow copy of the clock: registers, six digits, counts and mode.
    logic [3:0] tps_shadow        = TICKS_PER_SEC_RST;
    logic [3:0] idle_limit_shadow = IDLE_LIMIT_RST;
    logic [3:0] digit [6]         = '{default: 4'd0};
    logic [2:0] cursor_shadow     = CUR_HOUR_TENS;
    logic [4:0] hour_cnt          = 5'd0;
    logic [5:0] min_cnt           = 6'd0;
    logic [5:0] sec_cnt           = 6'd0;
    logic [3:0] tick_cnt          = 4'd0;
    logic [3:0] idle_cnt          = 4'd0;
    logic       editing_now       = 1'b0;

    // Idle rates in percent for the sender and the receiver.
    int send_idle_pct = 21;
    int stall_pct     = 21;

    int cycles;
    int mismatches;
    int n_queued;
    int n_random;
    int n_results;
    int n_accepted;
    int n_beeps;
    int n_timeouts;
    int n_rollovers;
    int n_settings;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Shadow model of the clock.
    // ---------------------------------------------------------------

    // One second passes in run mode, with carries up into the hours.
    // Hours of 24 or more, which a stale edit can leave behind, wrap to zero.
    function automatic void add_one_second();
        if (int'(sec_cnt) + 1 >= 60)
        begin
            sec_cnt = 6'd0;
            if (int'(min_cnt) + 1 >= 60)
            begin
                min_cnt = 6'd0;
                if (int'(hour_cnt) + 1 >= 24)
                begin
                    hour_cnt = 5'd0;
                    n_rollovers++;
                end
                else
                begin
                    hour_cnt = hour_cnt + 5'd1;
                end
            end
            else
            begin
                min_cnt = min_cnt + 6'd1;
            end
        end
        else
        begin
            sec_cnt = sec_cnt + 6'd1;
        end
    endfunction

    // Stores a digit at the cursor if it is legal there; returns the beep flag.
    // Every digit key rebuilds the three counts from the six digits.
    function automatic logic place_digit(input logic [3:0] d);
        logic ok;
        ok = 1'b1;
        case (cursor_shadow)
            CUR_HOUR_TENS:  if (d < 3) digit[0] = d; else ok = 1'b0;
            CUR_HOUR_UNITS: if (digit[0] < 2 || d < 4) digit[1] = d; else ok = 1'b0;
            CUR_MIN_TENS:   if (d < 6) digit[2] = d; else ok = 1'b0;
            CUR_MIN_UNITS:  digit[3] = d;
            CUR_SEC_TENS:   if (d < 6) digit[4] = d; else ok = 1'b0;
            CUR_SEC_UNITS:  digit[5] = d;
            default:        return 1'b0;
        endcase
        if (ok)
            cursor_shadow = (cursor_shadow >= CUR_SEC_UNITS) ? CUR_HOUR_TENS
                                                             : cursor_shadow + 3'd1;
        hour_cnt = 5'(digit[0] * 10 + digit[1]);
        min_cnt  = 6'(digit[2] * 10 + digit[3]);
        sec_cnt  = 6'(digit[4] * 10 + digit[5]);
        return !ok;
    endfunction

    // Applies one accepted beat to the shadow clock and returns the reading
    // that the block must show for it.
    function automatic result_t predict_display(input beat_t b);
        result_t r;
        logic    second_done;
        r = '0;
        second_done = 1'b0;
        case (b.func)
            FUNC_TICK:
            begin
                tick_cnt = tick_cnt + 4'd1;
                if (tick_cnt >= tps_shadow)
                begin
                    tick_cnt = 4'd0;
                    second_done = 1'b1;
                end
                if (!editing_now)
                begin
                    if (second_done)
                        add_one_second();
                end
                else
                begin
                    if (second_done && idle_cnt < IDLE_MAX)
                        idle_cnt = idle_cnt + 4'd1;
                    if (idle_cnt >= idle_limit_shadow)
                    begin
                        editing_now = 1'b0;
                        tick_cnt = 4'd0;
                        n_timeouts++;
                    end
                end
            end
            FUNC_KEY:
            begin
                if (editing_now)
                begin
                    if (b.key == KEY_CLEAR)
                    begin
                        digit = '{default: 4'd0};
                        cursor_shadow = CUR_HOUR_TENS;
                        hour_cnt = 5'd0;
                        min_cnt = 6'd0;
                        sec_cnt = 6'd0;
                    end
                    else if (b.key < KEY_DIGIT_LIMIT)
                    begin
                        r.beep = place_digit(b.key);
                    end
                    else if (b.key == KEY_EXIT)
                    begin
                        editing_now = 1'b0;
                        tick_cnt = 4'd0;
                    end
                    idle_cnt = 4'd0;
                end
            end
            FUNC_SET_MODE:
            begin
                editing_now = 1'b1;
                idle_cnt = 4'd0;
            end
            default: ;
        endcase
        r.hours        = hour_cnt;
        r.minutes      = min_cnt;
        r.seconds      = sec_cnt;
        r.cursor       = cursor_shadow;
        r.editing      = editing_now;
        r.idle_seconds = idle_cnt;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: one beat per handshake, held steady while stalled.
    // A new beat is taken from the queue only when the slot is free,
    // and the sender idles at random between beats.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : drive_beats
        beat_t sent;
        beat_t next_beat;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sent.func = func;
                sent.key  = key_code;
                expected_times.push_back(predict_display(sent));
                n_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_beat = beats_to_send.pop_front();
                    in_valid <= 1'b1;
                    func     <= next_beat.func;
                    key_code <= next_beat.key;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver stalls at random, independent of what the block offers.
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // ---------------------------------------------------------------
    // Scoreboard: each accepted result beat against the oldest reading owed.
    // ---------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : score_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_times.size() == 0)
            begin
                $error("result beat arrived with no reading expected");
                mismatches++;
            end
            else
            begin
                want = expected_times.pop_front();
                check_field("hours",        8'(want.hours),        8'(hours));
                check_field("minutes",      8'(want.minutes),      8'(minutes));
                check_field("seconds",      8'(want.seconds),      8'(seconds));
                check_field("cursor",       8'(want.cursor),       8'(cursor));
                check_field("editing",      8'(want.editing),      8'(editing));
                check_field("beep",         8'(want.beep),         8'(beep));
                check_field("idle_seconds", 8'(want.idle_seconds), 8'(idle_seconds));
                if (want.beep)
                    n_beeps++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d readings outstanding",
                     cycles, expected_times.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers.
    // ---------------------------------------------------------------
    task automatic push_beat(input logic [1:0] f, input logic [3:0] k);
        beat_t b;
        b.func = f;
        b.key  = k;
        beats_to_send.push_back(b);
        n_queued++;
    endtask

    // A beat that does real work counts toward the random budget.
    task automatic push_counted(input logic [1:0] f, input logic [3:0] k);
        push_beat(f, k);
        n_random++;
    endtask

    // Every beat yields exactly one result, so once the result count has caught
    // up with the queued count the block holds no work at all.
    task automatic wait_until_quiet();
        while (n_results != n_queued)
            @(posedge clk);
    endtask

    // Register writes happen only while the block is quiet, so the shadow copy
    // can follow at once.
    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_TICKS_PER_SECOND)
            tps_shadow = val;
        else
            idle_limit_shadow = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random stretch of use. Most of it is well-formed: runs of ticks, and
    // edit sessions that enter a legal time or type freely and then leave by the
    // exit key or by timing out. The rest is noise the block has to ignore.
    task automatic queue_session();
        int         pick;
        int         sel;
        int         n;
        logic [3:0] d;
        logic [3:0] tens;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            n = $urandom_range(1, 24);
            repeat (n) push_counted(FUNC_TICK, 4'($urandom));
        end
        else if (pick < 6)
        begin
            // Full legal entry; about a third of them sit just before midnight.
            push_counted(FUNC_SET_MODE, 4'($urandom));
            push_counted(FUNC_KEY, KEY_CLEAR);
            if ($urandom_range(0, 2) == 0)
            begin
                push_counted(FUNC_KEY, 4'd2);
                push_counted(FUNC_KEY, 4'd3);
                push_counted(FUNC_KEY, 4'd5);
                push_counted(FUNC_KEY, 4'd9);
                push_counted(FUNC_KEY, 4'd5);
                push_counted(FUNC_KEY, 4'($urandom_range(0, 9)));
            end
            else
            begin
                tens = 4'($urandom_range(0, 2));
                push_counted(FUNC_KEY, tens);
                push_counted(FUNC_KEY, 4'($urandom_range(0, (tens == 2) ? 3 : 9)));
                // An occasional illegal digit beeps and leaves the cursor alone.
                if ($urandom_range(0, 4) == 0)
                    push_counted(FUNC_KEY, 4'($urandom_range(6, 9)));
                push_counted(FUNC_KEY, 4'($urandom_range(0, 5)));
                push_counted(FUNC_KEY, 4'($urandom_range(0, 9)));
                push_counted(FUNC_KEY, 4'($urandom_range(0, 5)));
                push_counted(FUNC_KEY, 4'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 3) != 0)
                push_counted(FUNC_KEY, KEY_EXIT);
            else
                repeat ($urandom_range(1, 40)) push_counted(FUNC_TICK, 4'($urandom));
        end
        else if (pick < 8)
        begin
            // Free typing with ticks, clears and stray keys mixed in.
            push_counted(FUNC_SET_MODE, 4'($urandom));
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                sel = $urandom_range(0, 9);
                d = 4'($urandom_range(0, 9));
                if (sel < 7)
                    push_counted(FUNC_KEY, d);
                else if (sel == 7)
                    push_counted(FUNC_TICK, 4'($urandom));
                else if (sel == 8)
                    push_counted(FUNC_KEY, KEY_CLEAR);
                else
                    push_counted(FUNC_KEY, 4'($urandom));
            end
            if ($urandom_range(0, 1) == 0)
                push_counted(FUNC_KEY, KEY_EXIT);
            else
                repeat ($urandom_range(1, 40)) push_counted(FUNC_TICK, 4'($urandom));
        end
        else
        begin
            // Noise: the unused code, keys in run mode and anything else.
            repeat ($urandom_range(1, 3)) push_beat(2'($urandom), 4'($urandom));
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence.
    // ---------------------------------------------------------------
    logic [3:0] tps_plan  [PHASES] = '{4'd10, 4'd1, 4'd15, 4'd0, 4'd1, 4'd2, 4'd5};
    logic [3:0] idle_plan [PHASES] = '{4'd10, 4'd1, 4'd12, 4'd0, 4'd15, 4'd4, 4'd7};

    initial
    begin : run_test
        int p;
        int budget;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats: one second per tick and a short idle limit, so that
        // the carry and the timeout show up within a few beats.
        write_reg(REG_TICKS_PER_SECOND, 4'd1);
        write_reg(REG_IDLE_LIMIT, 4'd2);
        n_settings++;
        push_beat(FUNC_UNUSED, KEY_EXIT);       // unused code does nothing
        push_beat(FUNC_KEY, 4'd5);              // key in run mode is ignored
        push_beat(FUNC_TICK, 4'd0);             // one second
        push_beat(FUNC_SET_MODE, 4'd0);
        push_beat(FUNC_SET_MODE, 4'd15);        // enter again while already editing
        push_beat(FUNC_KEY, 4'd3);              // hour tens above 2 beeps
        push_beat(FUNC_KEY, 4'd1);
        push_beat(FUNC_KEY, 4'd9);              // 19 hours
        push_beat(FUNC_KEY, 4'd6);              // minute tens above 5 beeps
        push_beat(FUNC_KEY, 4'd5);
        push_beat(FUNC_KEY, 4'd9);
        push_beat(FUNC_KEY, 4'd5);
        push_beat(FUNC_KEY, 4'd9);              // 19:59:59, cursor wraps to hour tens
        push_beat(FUNC_KEY, 4'd2);              // stale hour unit leaves 29 hours
        push_beat(FUNC_KEY, 4'd4);              // hour unit above 3 after a 2 beeps
        for (int k = KEY_DIGIT_LIMIT; k < KEY_EXIT; k++)
            if (k != KEY_CLEAR)
                push_beat(FUNC_KEY, 4'(k));     // keys with no function
        push_beat(FUNC_KEY, KEY_EXIT);
        push_beat(FUNC_TICK, 4'd15);            // carry wraps 29 hours to midnight
        push_beat(FUNC_SET_MODE, 4'd0);
        push_beat(FUNC_TICK, 4'd0);
        push_beat(FUNC_TICK, 4'd0);             // idle limit reached, set mode ends
        push_beat(FUNC_SET_MODE, 4'd0);
        push_beat(FUNC_KEY, KEY_CLEAR);
        push_beat(FUNC_KEY, 4'd0);
        push_beat(FUNC_KEY, KEY_EXIT);
        wait_until_quiet();

        // Random phases, each under its own register setting. Between phases the
        // sender holds off until every owed reading is back. The third phase runs
        // with no idling on either side.
        budget = RANDOM_BEATS / PHASES;
        for (p = 0; p < PHASES; p++)
        begin
            write_reg(REG_TICKS_PER_SECOND, tps_plan[p]);
            write_reg(REG_IDLE_LIMIT, idle_plan[p]);
            n_settings++;
            send_idle_pct = (p == 2) ? 0 : 21;
            stall_pct     = (p == 2) ? 0 : 21;
            n_random = 0;
            while (n_random < budget)
                queue_session();
            wait_until_quiet();
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        if (expected_times.size() != 0)
        begin
            $error("%0d expected readings never arrived", expected_times.size());
            mismatches++;
        end
        $display("Sent %0d beats under %0d register settings; checked %0d readings.",
                 n_accepted, n_settings, n_results);
        $display("Saw %0d rejected digits, %0d set-mode timeouts, %0d midnight rollovers.",
                 n_beeps, n_timeouts, n_rollovers);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
